// ===== src/isl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isl_pkg;

    // Storage geometry
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    // Field widths of the stream payloads
    localparam int CMD_W   = 3;
    localparam int POS_W   = 8;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 7;

    // Index into the cell row, count of held entries, and a width wide enough
    // to compare a position against the count plus one without overflow.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Packed stream widths, rounded up to whole bytes
    localparam int S_BITS   = CMD_W + POS_W + VALUE_W;
    localparam int M_BITS   = VALUE_W + STAT_W + ECNT_W + 1;
    localparam int S_DATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_REAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REM_POS   = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // Shift control broadcast to every cell of the row
    typedef struct packed {
        logic                  ins;
        logic                  rem;
        logic [IDX_W-1:0]      idx;
        logic [DATA_WIDTH-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/indexed_sequence_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to CAPACITY values held in a row of shifting cells.
// Slave channel (s_*): one command per transaction. Master channel (m_*):
// exactly one result per command, in command order.
// Commands add or remove at the front, the rear, or a one-based position.
// A removal returns the removed value; every result carries status, the
// count held afterwards and an empty flag.
// The result is registered and is valid in the cycle after the command is accepted.
// Throughput: one command per cycle. Each cell compares its own index with
// the decoded shift index and loads from its left or right neighbor, so any
// insert or removal completes in the same cycle that accepts it.
// The result sits in an output register; a new command is accepted while
// that register is empty or being read in the same cycle. When the receiver
// stalls, the result holds and s_tready drops until it is taken.
// Reset (aresetn low, synchronous) empties the list and drops m_tvalid;
// cell contents are not cleared and are never read before being written.
// No startup sweep is needed: the block accepts commands right after reset.

module indexed_sequence_list (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // [2:0] command, [10:3] position, [42:11] value_in, rest zero
    input  wire  [isl_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [31:0] value_out, [33:32] status, [40:34] entry_count, [41] is_empty
    output logic [isl_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int POS_LO = isl_pkg::CMD_W;
    localparam int VAL_LO = isl_pkg::CMD_W + isl_pkg::POS_W;

    logic [isl_pkg::CMD_W-1:0]   s_command;
    logic [isl_pkg::POS_W-1:0]   s_position;
    logic [isl_pkg::VALUE_W-1:0] s_value_in;
    logic                        accept;

    isl_pkg::cell_ctrl_t          dec_ctrl;
    isl_pkg::cell_ctrl_t          cell_ctrl;
    logic [isl_pkg::STAT_W-1:0]   dec_status;
    logic [isl_pkg::CNT_W-1:0]    dec_count;

    logic [isl_pkg::CNT_W-1:0]    count_reg;
    logic [isl_pkg::CNT_W-1:0]    count_next;

    logic [isl_pkg::DATA_WIDTH-1:0] cell_data [isl_pkg::CAPACITY];
    logic [isl_pkg::DATA_WIDTH-1:0] cell_tap  [isl_pkg::CAPACITY];
    logic [isl_pkg::DATA_WIDTH-1:0] removed;

    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [isl_pkg::VALUE_W-1:0]  value_out_reg;
    logic [isl_pkg::STAT_W-1:0]   status_reg;
    logic [isl_pkg::CNT_W-1:0]    result_count_reg;
    logic [isl_pkg::CMP_W-1:0]    result_count_ext;

    // Unpack the command transaction
    assign s_command  = s_tdata[isl_pkg::CMD_W-1:0];
    assign s_position = s_tdata[POS_LO +: isl_pkg::POS_W];
    assign s_value_in = s_tdata[VAL_LO +: isl_pkg::VALUE_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    isl_decode u_decode (
        .command    (s_command),
        .position   (s_position),
        .value_in   (s_value_in),
        .count      (count_reg),
        .ctrl       (dec_ctrl),
        .status     (dec_status),
        .count_next (dec_count)
    );

    // Cells shift only on an accepted command.
    always_comb begin
        cell_ctrl     = dec_ctrl;
        cell_ctrl.ins = dec_ctrl.ins && accept;
        cell_ctrl.rem = dec_ctrl.rem && accept;
    end

    // Row of cells, each linked to both neighbors
    for (genvar i = 0; i < isl_pkg::CAPACITY; i++) begin : g_cell
        logic [isl_pkg::DATA_WIDTH-1:0] left_data;
        logic [isl_pkg::DATA_WIDTH-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid_left
            assign left_data = cell_data[i-1];
        end

        if (i == isl_pkg::CAPACITY - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_mid_right
            assign right_data = cell_data[i+1];
        end

        isl_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .cell_index (isl_pkg::IDX_W'(i)),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    // Only the cell at the removal index drives a nonzero tap.
    always_comb begin
        removed = '0;
        for (int i = 0; i < isl_pkg::CAPACITY; i++) begin
            removed = removed | cell_tap[i];
        end
    end

    // Held count
    always_comb begin
        count_next = count_reg;
        if (accept) begin
            count_next = dec_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            value_out_reg    <= isl_pkg::VALUE_W'(removed);
            status_reg       <= dec_status;
            result_count_reg <= dec_count;
        end
    end

    assign result_count_ext = isl_pkg::CMP_W'(result_count_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = isl_pkg::M_DATA_W'({
        (result_count_reg == '0),
        result_count_ext[isl_pkg::ECNT_W-1:0],
        status_reg,
        value_out_reg
    });

endmodule

`default_nettype wire

// ===== src/isl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isl_cell (
    input  wire                                 aclk,
    input  wire isl_pkg::cell_ctrl_t            ctrl,
    input  wire  [isl_pkg::IDX_W-1:0]           cell_index,
    input  wire  [isl_pkg::DATA_WIDTH-1:0]      left_data,
    input  wire  [isl_pkg::DATA_WIDTH-1:0]      right_data,
    output logic [isl_pkg::DATA_WIDTH-1:0]      data,
    output logic [isl_pkg::DATA_WIDTH-1:0]      tap
);

    logic [isl_pkg::DATA_WIDTH-1:0] data_reg;
    logic [isl_pkg::DATA_WIDTH-1:0] data_next;
    logic                           at_idx;
    logic                           after_idx;

    assign at_idx    = (cell_index == ctrl.idx);
    assign after_idx = (cell_index > ctrl.idx);

    // An insert opens a gap at the index and pushes later cells to the rear;
    // a removal closes the gap by pulling from the rear neighbor.
    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            if (at_idx) begin
                data_next = ctrl.value;
            end else if (after_idx) begin
                data_next = left_data;
            end
        end else if (ctrl.rem) begin
            if (at_idx || after_idx) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // The cell at the removal index offers its value to the result bus.
    assign tap  = (ctrl.rem && at_idx) ? data_reg : '0;
    assign data = data_reg;

endmodule

`default_nettype wire

// ===== src/isl_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isl_decode (
    input  wire  [isl_pkg::CMD_W-1:0]      command,
    input  wire  [isl_pkg::POS_W-1:0]      position,
    input  wire  [isl_pkg::VALUE_W-1:0]    value_in,
    input  wire  [isl_pkg::CNT_W-1:0]      count,
    output isl_pkg::cell_ctrl_t            ctrl,
    output logic [isl_pkg::STAT_W-1:0]     status,
    output logic [isl_pkg::CNT_W-1:0]      count_next
);

    logic [isl_pkg::CMP_W-1:0] pos_ext;
    logic [isl_pkg::CMP_W-1:0] pos_m1;
    logic [isl_pkg::CMP_W-1:0] cnt_ext;
    logic [isl_pkg::CMP_W-1:0] cnt_m1;
    logic                      full;
    logic                      empty;

    assign pos_ext = isl_pkg::CMP_W'(position);
    assign pos_m1  = pos_ext - isl_pkg::CMP_W'(1);
    assign cnt_ext = isl_pkg::CMP_W'(count);
    assign cnt_m1  = cnt_ext - isl_pkg::CMP_W'(1);
    assign full    = (cnt_ext >= isl_pkg::CMP_W'(isl_pkg::CAPACITY));
    assign empty   = (count == '0);

    // Command decode: legality checks, shift index and the new count.
    always_comb begin
        ctrl.ins   = 1'b0;
        ctrl.rem   = 1'b0;
        ctrl.idx   = '0;
        ctrl.value = isl_pkg::DATA_WIDTH'(value_in);
        status     = isl_pkg::ST_OK;
        case (command)
            isl_pkg::CMD_ADD_FRONT: begin
                if (full) begin
                    status = isl_pkg::ST_FULL;
                end else begin
                    ctrl.ins = 1'b1;
                end
            end
            isl_pkg::CMD_ADD_REAR: begin
                if (full) begin
                    status = isl_pkg::ST_FULL;
                end else begin
                    ctrl.ins = 1'b1;
                    ctrl.idx = cnt_ext[isl_pkg::IDX_W-1:0];
                end
            end
            isl_pkg::CMD_REM_FRONT: begin
                if (empty) begin
                    status = isl_pkg::ST_UNDERFLOW;
                end else begin
                    ctrl.rem = 1'b1;
                end
            end
            isl_pkg::CMD_REM_REAR: begin
                if (empty) begin
                    status = isl_pkg::ST_UNDERFLOW;
                end else begin
                    ctrl.rem = 1'b1;
                    ctrl.idx = cnt_m1[isl_pkg::IDX_W-1:0];
                end
            end
            isl_pkg::CMD_INS_POS: begin
                if (pos_ext == '0 || pos_ext > cnt_ext + isl_pkg::CMP_W'(1)) begin
                    status = isl_pkg::ST_RANGE;
                end else if (full) begin
                    status = isl_pkg::ST_FULL;
                end else begin
                    ctrl.ins = 1'b1;
                    ctrl.idx = pos_m1[isl_pkg::IDX_W-1:0];
                end
            end
            isl_pkg::CMD_REM_POS: begin
                if (pos_ext == '0 || pos_ext > cnt_ext) begin
                    status = isl_pkg::ST_RANGE;
                end else begin
                    ctrl.rem = 1'b1;
                    ctrl.idx = pos_m1[isl_pkg::IDX_W-1:0];
                end
            end
            default: begin
                status = isl_pkg::ST_RANGE;
            end
        endcase
    end

    // Count after the command
    always_comb begin
        count_next = count;
        if (ctrl.ins) begin
            count_next = count + isl_pkg::CNT_W'(1);
        end else if (ctrl.rem) begin
            count_next = count - isl_pkg::CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== src/isl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isl_protocol_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire [isl_pkg::S_DATA_W-1:0]  s_tdata,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [isl_pkg::M_DATA_W-1:0]  m_tdata
);

    logic [isl_pkg::VALUE_W-1:0] chk_value;
    logic [isl_pkg::STAT_W-1:0]  chk_status;
    logic [isl_pkg::ECNT_W-1:0]  chk_count;
    logic                        chk_empty;
    logic                        chk_in_seen;

    assign chk_value   = m_tdata[31:0];
    assign chk_status  = m_tdata[33:32];
    assign chk_count   = m_tdata[40:34];
    assign chk_empty   = m_tdata[41];
    assign chk_in_seen = s_tvalid;

    // A stalled result stays valid and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A failed command returns no value: its value field is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_status != isl_pkg::ST_OK |-> chk_value == '0)
        else $error("value returned on a failed command");

    // Underflow only happens on an empty list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_status == isl_pkg::ST_UNDERFLOW |-> chk_empty && chk_count == '0)
        else $error("underflow reported on a non-empty list");

    // A full report shows the list at capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_status == isl_pkg::ST_FULL
        |-> chk_count == isl_pkg::ECNT_W'(isl_pkg::CAPACITY) && !chk_empty)
        else $error("full reported below capacity");

    // Every accepted command yields a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        chk_in_seen && s_tready |=> m_tvalid)
        else $error("accepted command produced no result");

endmodule

bind indexed_sequence_list isl_protocol_checker u_isl_checker (.*);

`default_nettype wire
